### design/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // Hue ranges in hundredths of a degree.
  localparam logic [15:0] HUE_TURN   = 16'd36000;
  localparam logic [15:0] HUE_SECTOR = 16'd6000;

  localparam logic [9:0]  SAT_FULL   = 10'd1000;

  // Divisors left after the powers of two are taken out of 2^16/1000,
  // 2^16/10^6 and 2^16/6000.
  localparam logic [7:0]  DIV_V = 8'd125;
  localparam logic [13:0] DIV_C = 14'd15625;
  localparam logic [8:0]  DIV_F = 9'd375;

  // floor(2^32 / divisor); the estimate is low by at most one.
  localparam logic [25:0] RECIP_V = 26'd34359738;
  localparam logic [18:0] RECIP_C = 19'd274877;
  localparam logic [23:0] RECIP_F = 24'd11453246;

  // Fixed-point values with 16 fractional bits; up to 67043 for V and C.
  localparam int unsigned Q_W = 17;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

  typedef struct packed {
    logic [15:0] hue_centideg;
    logic [9:0]  saturation_permille;
    logic [9:0]  brightness_permille;
  } hsvrgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsvrgb_out_t;

  typedef struct packed {
    sector_t          sector;
    logic [12:0]      hue_offset;
    logic [Q_W-1:0]   frac_est;
    logic [19:0]      sv_prod;
    logic [Q_W-1:0]   chroma_est;
    logic [Q_W-1:0]   value_q;
  } hsvrgb_prep_t;

  typedef struct packed {
    sector_t          sector;
    logic [Q_W-1:0]   chroma_q;
    logic [Q_W-1:0]   x_q;
    logic [Q_W-1:0]   offset_q;
  } hsvrgb_chroma_t;

endpackage

### design/hsvrgb_prep.sv
module hsvrgb_prep (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  input  hsvrgb_pkg::hsvrgb_in_t   up_data,
  output logic                     up_ready,
  output logic                     dn_valid,
  output hsvrgb_pkg::hsvrgb_prep_t dn_data,
  input  logic                     dn_ready
);
  import hsvrgb_pkg::*;

  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic rdy1, rdy2, rdy3;

  logic [15:0] s1_hue_r, hue_nxt;
  logic [9:0]  s1_sat_r, sat_nxt;
  logic [9:0]  s1_bri_r;

  sector_t        s2_sector_r, sector_nxt;
  logic [12:0]    s2_offset_r, offset_nxt;
  logic [19:0]    s2_sv_r, sv_nxt;
  logic [Q_W-1:0] s2_vest_r, vest_nxt;
  logic [9:0]     s2_bri_r;
  logic [15:0]    sector_base;
  logic [12:0]    raw_offset;
  logic [35:0]    vprod;

  hsvrgb_prep_t s3_data_r, s3_nxt;
  logic [36:0]  fprod;
  logic [38:0]  cprod;
  logic [23:0]  vback, vrem;

  assign rdy3     = !s3_valid_r || dn_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign up_ready = rdy1;

  // Stage 1: reduce the hue to one turn and clamp the saturation.
  always_comb begin
    hue_nxt = (up_data.hue_centideg >= HUE_TURN) ?
              (up_data.hue_centideg - HUE_TURN) : up_data.hue_centideg;
    sat_nxt = (up_data.saturation_permille > SAT_FULL) ?
              SAT_FULL : up_data.saturation_permille;
  end

  // Stage 2: sector search, offset inside the sector, and the first products.
  always_comb begin
    if (s1_hue_r >= HUE_SECTOR * 16'd5) begin
      sector_nxt  = SEC_MAGENTA_RED;
      sector_base = HUE_SECTOR * 16'd5;
    end else if (s1_hue_r >= HUE_SECTOR * 16'd4) begin
      sector_nxt  = SEC_BLUE_MAGENTA;
      sector_base = HUE_SECTOR * 16'd4;
    end else if (s1_hue_r >= HUE_SECTOR * 16'd3) begin
      sector_nxt  = SEC_CYAN_BLUE;
      sector_base = HUE_SECTOR * 16'd3;
    end else if (s1_hue_r >= HUE_SECTOR * 16'd2) begin
      sector_nxt  = SEC_GREEN_CYAN;
      sector_base = HUE_SECTOR * 16'd2;
    end else if (s1_hue_r >= HUE_SECTOR) begin
      sector_nxt  = SEC_YELLOW_GREEN;
      sector_base = HUE_SECTOR;
    end else begin
      sector_nxt  = SEC_RED_YELLOW;
      sector_base = 16'd0;
    end
    raw_offset = 13'(s1_hue_r - sector_base);
    // Odd sectors run the ramp downward.
    if (sector_nxt == SEC_YELLOW_GREEN || sector_nxt == SEC_CYAN_BLUE ||
        sector_nxt == SEC_MAGENTA_RED) begin
      offset_nxt = HUE_SECTOR[12:0] - raw_offset;
    end else begin
      offset_nxt = raw_offset;
    end
    sv_nxt   = 20'(s1_sat_r) * 20'(s1_bri_r);
    vprod    = 36'(s1_bri_r) * 36'(RECIP_V);
    vest_nxt = vprod[35:19];
  end

  // Stage 3: reciprocal estimates for hue fraction and chroma; finish V.
  always_comb begin
    fprod = 37'(s2_offset_r) * 37'(RECIP_F);
    cprod = 39'(s2_sv_r) * 39'(RECIP_C);
    vback = 24'(s2_vest_r) * 24'(DIV_V);
    vrem  = 24'({s2_bri_r, 13'd0}) - vback;
    s3_nxt.sector     = s2_sector_r;
    s3_nxt.hue_offset = s2_offset_r;
    s3_nxt.frac_est   = fprod[36:20];
    s3_nxt.sv_prod    = s2_sv_r;
    s3_nxt.chroma_est = cprod[38:22];
    s3_nxt.value_q    = (vrem >= 24'(DIV_V)) ? (s2_vest_r + 17'd1) : s2_vest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= up_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_hue_r <= hue_nxt;
      s1_sat_r <= sat_nxt;
      s1_bri_r <= up_data.brightness_permille;
    end
    if (rdy2) begin
      s2_sector_r <= sector_nxt;
      s2_offset_r <= offset_nxt;
      s2_sv_r     <= sv_nxt;
      s2_vest_r   <= vest_nxt;
      s2_bri_r    <= s1_bri_r;
    end
    if (rdy3) begin
      s3_data_r <= s3_nxt;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_data  = s3_data_r;

`ifndef NO_ASSERTIONS
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> s2_offset_r <= HUE_SECTOR[12:0])
    else $error("hue offset exceeds one sector");
  a_value_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> s3_data_r.value_q <= 17'd67043)
    else $error("brightness quotient out of range");
  a_hue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_hue_r < HUE_TURN)
    else $error("hue not reduced to one turn");
`endif

endmodule

### design/hsvrgb_chroma.sv
module hsvrgb_chroma (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  hsvrgb_pkg::hsvrgb_prep_t   up_data,
  output logic                       up_ready,
  output logic                       dn_valid,
  output hsvrgb_pkg::hsvrgb_chroma_t dn_data,
  input  logic                       dn_ready
);
  import hsvrgb_pkg::*;

  logic s4_valid_r, s5_valid_r;
  logic rdy4, rdy5;

  sector_t        s4_sector_r;
  logic [Q_W-1:0] s4_frac_r, frac_nxt;
  logic [Q_W-1:0] s4_c_r, c_nxt;
  logic [Q_W-1:0] s4_v_r;
  logic [24:0]    fback, frem;
  logic [29:0]    cback, crem;

  hsvrgb_chroma_t s5_data_r, s5_nxt;
  logic [33:0]    xprod;

  assign rdy5     = !s5_valid_r || dn_ready;
  assign rdy4     = !s4_valid_r || rdy5;
  assign up_ready = rdy4;

  // Stage 4: one correction step turns each estimate into the exact quotient.
  always_comb begin
    fback    = 25'(up_data.frac_est) * 25'(DIV_F);
    frem     = 25'({up_data.hue_offset, 12'd0}) - fback;
    frac_nxt = (frem >= 25'(DIV_F)) ? (up_data.frac_est + 17'd1) : up_data.frac_est;
    cback    = 30'(up_data.chroma_est) * 30'(DIV_C);
    crem     = 30'({up_data.sv_prod, 10'd0}) - cback;
    c_nxt    = (crem >= 30'(DIV_C)) ? (up_data.chroma_est + 17'd1) : up_data.chroma_est;
  end

  // Stage 5: X = C * F and the offset m = V - C.
  always_comb begin
    xprod            = 34'(s4_c_r) * 34'(s4_frac_r);
    s5_nxt.sector    = s4_sector_r;
    s5_nxt.chroma_q  = s4_c_r;
    s5_nxt.x_q       = xprod[32:16];
    s5_nxt.offset_q  = s4_v_r - s4_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (rdy4) s4_valid_r <= up_valid;
      if (rdy5) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_sector_r <= up_data.sector;
      s4_frac_r   <= frac_nxt;
      s4_c_r      <= c_nxt;
      s4_v_r      <= up_data.value_q;
    end
    if (rdy5) begin
      s5_data_r <= s5_nxt;
    end
  end

  assign dn_valid = s5_valid_r;
  assign dn_data  = s5_data_r;

`ifndef NO_ASSERTIONS
  a_chroma_le_value: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> s4_c_r <= s4_v_r)
    else $error("chroma exceeds brightness");
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> s4_frac_r <= 17'd65536)
    else $error("hue fraction above one");
  a_x_le_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> s5_data_r.x_q <= s5_data_r.chroma_q)
    else $error("intermediate component exceeds chroma");
`endif

endmodule

### design/hsvrgb_mix.sv
module hsvrgb_mix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  hsvrgb_pkg::hsvrgb_chroma_t up_data,
  output logic                       up_ready,
  output logic                       dn_valid,
  output hsvrgb_pkg::hsvrgb_out_t    dn_data,
  input  logic                       dn_ready
);
  import hsvrgb_pkg::*;

  logic           out_valid_r;
  hsvrgb_out_t    out_data_r, out_nxt;
  logic [Q_W-1:0] part_r, part_g, part_b;

  // q * 255 / 2^16, truncated, clipped to eight bits.
  function automatic logic [7:0] scale_comp(input logic [Q_W-1:0] q);
    logic [24:0] prod;
    prod = {q, 8'd0} - 25'(q);
    return (prod[24:16] > 9'd255) ? 8'd255 : prod[23:16];
  endfunction

  always_comb begin
    case (up_data.sector)
      SEC_RED_YELLOW: begin
        part_r = up_data.chroma_q; part_g = up_data.x_q;      part_b = '0;
      end
      SEC_YELLOW_GREEN: begin
        part_r = up_data.x_q;      part_g = up_data.chroma_q; part_b = '0;
      end
      SEC_GREEN_CYAN: begin
        part_r = '0;               part_g = up_data.chroma_q; part_b = up_data.x_q;
      end
      SEC_CYAN_BLUE: begin
        part_r = '0;               part_g = up_data.x_q;      part_b = up_data.chroma_q;
      end
      SEC_BLUE_MAGENTA: begin
        part_r = up_data.x_q;      part_g = '0;               part_b = up_data.chroma_q;
      end
      default: begin
        part_r = up_data.chroma_q; part_g = '0;               part_b = up_data.x_q;
      end
    endcase
    out_nxt.red   = scale_comp(part_r + up_data.offset_q);
    out_nxt.green = scale_comp(part_g + up_data.offset_q);
    out_nxt.blue  = scale_comp(part_b + up_data.offset_q);
  end

  assign up_ready = !out_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      out_data_r <= out_nxt;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_black_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_ready && up_data.chroma_q == '0 && up_data.offset_q == '0)
      |=> (out_data_r.red == 8'd0 && out_data_r.green == 8'd0 &&
           out_data_r.blue == 8'd0))
    else $error("zero brightness did not give black");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_ready) |=> out_valid_r)
    else $error("loaded result not marked valid");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !dn_ready) |=> out_valid_r)
    else $error("stalled result dropped");
`endif

endmodule

### design/hsv_to_rgb_converter.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  hsvrgb_in_t  (hue, saturation, brightness)
// out_      output     out_valid / out_stall hsvrgb_out_t (red, green, blue)
//
// Six register stages: hue reduction, sector search with first products,
// reciprocal estimates, quotient correction, X = C * F, and the final
// placement and scaling into the output register. One transaction per
// cycle is accepted while in_stall is low; each stage holds while its
// successor is full and stalled, so empty stages still fill during a stall.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
module hsv_to_rgb_converter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  hsvrgb_pkg::hsvrgb_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output hsvrgb_pkg::hsvrgb_out_t out_data
);
  import hsvrgb_pkg::*;

  logic           prep_ready;
  logic           prep_valid, chroma_ready;
  hsvrgb_prep_t   prep_data;
  logic           chroma_valid, mix_ready;
  hsvrgb_chroma_t chroma_data;

  hsvrgb_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (prep_ready),
    .dn_valid (prep_valid),
    .dn_data  (prep_data),
    .dn_ready (chroma_ready)
  );

  hsvrgb_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_data  (prep_data),
    .up_ready (chroma_ready),
    .dn_valid (chroma_valid),
    .dn_data  (chroma_data),
    .dn_ready (mix_ready)
  );

  hsvrgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chroma_valid),
    .up_data  (chroma_data),
    .up_ready (mix_ready),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (!out_stall)
  );

  assign in_stall = !prep_ready;

`ifndef NO_ASSERTIONS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output register");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
